// ===== rtl/slips_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slips_pkg
// Shared types and codes for the sorted list insert / pop-min / search block.
// ----------------------------------------------------------------------------
package slips_pkg;

    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;
    localparam int REMOVAL_BITS = 20;
    localparam logic [REMOVAL_BITS-1:0] REMOVAL_MAX = '1;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_status status;
        logic    found;
    } t_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_POP_RD,
        S_POP_CMP,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/slips_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slips_ram
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slips_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 20,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/slips_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slips_core
// Sequencer over a circular key store with one shared key comparator:
// insert shifts the tail up one entry at a time, search is a binary search,
// remove advances the head pointer.
// ----------------------------------------------------------------------------
module slips_core import slips_pkg::*; #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 20,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [OP_BITS-1:0]      i_op,
    input  wire logic [KEY_BITS-1:0]     i_key,
    input  wire logic                    i_take,
    output logic                         o_idle,
    output logic                         o_done,
    output t_flags                       o_flags,
    output logic [KEY_BITS-1:0]          o_removed_key,
    output logic [CW-1:0]                o_occupancy,
    output logic [REMOVAL_BITS-1:0]      o_removals
);

    localparam logic [CW:0]   CAP_EXT  = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_HEAD = (AW + 1)'(CAPACITY);

    t_state r_state, n_state;

    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_head;
    logic [REMOVAL_BITS-1:0] r_removals;
    logic [KEY_BITS-1:0]     r_key;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_hi;
    logic [KEY_BITS-1:0]     r_popped;
    t_flags                  r_flags;

    logic [CW:0]         w_sum;
    logic [CW-1:0]       w_mid;
    logic [CW-1:0]       w_lidx;
    logic [CW:0]         w_psum;
    logic [CW:0]         w_pwrap;
    logic [AW-1:0]       w_paddr;
    logic [AW:0]         w_head_inc;
    logic [KEY_BITS-1:0] w_rdata;
    logic                w_lt;
    logic                w_eq;
    logic                w_we;
    logic [KEY_BITS-1:0] w_wdata;

    // binary search midpoint
    assign w_sum = {1'b0, r_idx} + {1'b0, r_hi};
    assign w_mid = w_sum[CW:1];

    // logical position addressed this cycle
    always_comb begin
        unique case (r_state)
            S_INS_CHK:  w_lidx = (r_idx == '0) ? r_idx : r_idx - 1'b1;
            S_INS_CMP:  w_lidx = r_idx;
            S_SRCH_CHK: w_lidx = w_mid;
            default:    w_lidx = '0;
        endcase
    end

    // logical to physical: head + position, wrapped once
    assign w_psum  = (CW + 1)'(r_head) + (CW + 1)'(w_lidx);
    assign w_pwrap = (w_psum >= CAP_EXT) ? w_psum - CAP_EXT : w_psum;
    assign w_paddr = w_pwrap[AW-1:0];

    assign w_head_inc = (AW + 1)'(r_head) + 1'b1;

    // shared comparator
    assign w_lt = w_rdata < r_key;
    assign w_eq = w_rdata == r_key;

    slips_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_paddr),
        .i_wdata (w_wdata),
        .i_raddr (w_paddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        OP_INSERT: n_state = (r_count == CAP_CNT) ? S_DONE : S_INS_CHK;
                        OP_REMOVE: n_state = (r_count == '0) ? S_DONE : S_POP_RD;
                        OP_SEARCH: n_state = S_SRCH_CHK;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INS_CHK:  n_state = (r_idx == '0) ? S_DONE : S_INS_CMP;
            S_INS_CMP:  n_state = w_lt ? S_DONE : S_INS_CHK;
            S_SRCH_CHK: n_state = (r_idx < r_hi) ? S_SRCH_CMP : S_DONE;
            S_SRCH_CMP: n_state = S_SRCH_CHK;
            S_POP_RD:   n_state = S_POP_CMP;
            S_POP_CMP:  n_state = S_DONE;
            S_DONE:     n_state = i_take ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs and store write
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_key;
        o_idle  = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE:    o_idle = 1'b1;
            S_INS_CHK: w_we   = (r_idx == '0);
            S_INS_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_lt ? r_key : w_rdata;
            end
            S_DONE:    o_done = 1'b1;
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_flags       = r_flags;
    assign o_removed_key = r_popped;
    assign o_occupancy   = r_count;
    assign o_removals    = r_removals;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_head     <= '0;
            r_removals <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_INS_CHK: begin
                    if (r_idx == '0) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_INS_CMP: begin
                    if (w_lt) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_POP_CMP: begin
                    r_head  <= (w_head_inc == CAP_HEAD) ? '0 : w_head_inc[AW-1:0];
                    r_count <= r_count - 1'b1;
                    if (r_removals != REMOVAL_MAX) begin
                        r_removals <= r_removals + 1'b1;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_key    <= i_key;
                    r_popped <= '0;
                    r_hi     <= r_count;
                    unique case (i_op)
                        OP_INSERT: begin
                            r_idx <= r_count;
                            if (r_count == CAP_CNT) begin
                                r_flags <= '{status: ST_FULL, found: 1'b0};
                            end else begin
                                r_flags <= '{status: ST_OK, found: 1'b0};
                            end
                        end
                        OP_REMOVE: begin
                            r_idx <= r_count;
                            if (r_count == '0) begin
                                r_flags <= '{status: ST_EMPTY, found: 1'b0};
                            end else begin
                                r_flags <= '{status: ST_OK, found: 1'b0};
                            end
                        end
                        OP_SEARCH: begin
                            r_idx   <= '0;
                            r_flags <= '{status: ST_OK, found: 1'b0};
                        end
                        default: begin
                            r_idx   <= r_count;
                            r_flags <= '{status: ST_OK, found: 1'b0};
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                if (!w_lt) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            S_SRCH_CMP: begin
                if (w_lt) begin
                    r_idx <= w_mid + 1'b1;
                end else begin
                    r_hi <= w_mid;
                end
                if (w_eq) begin
                    r_flags.found <= 1'b1;
                end
            end
            S_POP_CMP: r_popped <= w_rdata;
            default: begin
                r_key <= r_key;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/sorted_list_insert_popmin_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_popmin_search
// Bounded ascending key list with insert, remove-minimum and search, one
// result per request.
// ----------------------------------------------------------------------------
// throughput: one request at a time; the store, whose read and write ports
//   share one address, sets the insert and search loop rate
// reset: synchronous active low, empties the list and clears the removal count
module sorted_list_insert_popmin_search import slips_pkg::*; #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_BITS  = 20,
    localparam int OCC_BITS = $clog2(CAPACITY + 1),
    localparam int IN_W     = ((OP_BITS + KEY_BITS + 7) / 8) * 8,
    localparam int OUT_RAW  = STATUS_BITS + KEY_BITS + 1 + OCC_BITS + REMOVAL_BITS,
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // operation, key
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // status, removed_key, found, occupancy, removals_done
    output logic [OUT_W-1:0]      m_axis_tdata
);

    logic                    w_idle;
    logic                    w_done;
    logic                    w_take;
    t_flags                  w_flags;
    logic [KEY_BITS-1:0]     w_removed_key;
    logic [OCC_BITS-1:0]     w_occupancy;
    logic [REMOVAL_BITS-1:0] w_removals;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    assign s_axis_tready = w_idle;
    assign w_take        = w_done && (!r_out_valid || m_axis_tready);

    slips_core #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (s_axis_tvalid && w_idle),
        .i_op          (s_axis_tdata[OP_BITS-1:0]),
        .i_key         (s_axis_tdata[OP_BITS +: KEY_BITS]),
        .i_take        (w_take),
        .o_idle        (w_idle),
        .o_done        (w_done),
        .o_flags       (w_flags),
        .o_removed_key (w_removed_key),
        .o_occupancy   (w_occupancy),
        .o_removals    (w_removals)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= OUT_W'({w_removals, w_occupancy, w_flags.found,
                                  w_removed_key, w_flags.status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the sorted key list: insert, pop-min, search and the
// unused opcode are driven through the request port. A queue-based shadow
// list predicts every response, and the response port is checked against it
// while the source idles and the sink stalls in several phases.
// ----------------------------------------------------------------------------
module tb;
    import slips_pkg::*;

    localparam int CAPACITY   = 1024;
    localparam int KEY_BITS   = 20;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 56;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
    localparam logic [KEY_BITS-1:0] MID_KEY = 20'd500001;

    typedef struct {
        logic [1:0]          op;
        logic [KEY_BITS-1:0] key;
        bit                  wait_idle;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [KEY_BITS-1:0] removed_key;
        logic                found;
        logic [10:0]         occupancy;
        logic [19:0]         removals_done;
    } t_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    t_req                pending_reqs[$];
    t_result             expected_results[$];
    logic [KEY_BITS-1:0] shadow_list[$];
    logic [19:0]         shadow_pops = '0;
    logic [1:0]          cur_op = '0;
    logic [KEY_BITS-1:0] cur_key = '0;
    int                  src_idle_pct = 0;
    int                  sink_stall_pct = 0;
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    // request generator bookkeeping
    int                  gen_occ = 0;
    logic [KEY_BITS-1:0] recent_keys[16];
    int                  recent_n = 0;

    sorted_list_insert_popmin_search #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // applies one request to the shadow list and returns the response
    function automatic t_result list_op_result(logic [1:0] op, logic [KEY_BITS-1:0] key);
        t_result r;
        int      pos;
        r = '{status: ST_OK, removed_key: '0, found: 1'b0, occupancy: '0,
              removals_done: '0};
        if (op == OP_INSERT) begin
            if (shadow_list.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_list.size() && shadow_list[pos] < key) pos++;
                shadow_list.insert(pos, key);
            end
        end else if (op == OP_REMOVE) begin
            if (shadow_list.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_key = shadow_list.pop_front();
                if (shadow_pops != REMOVAL_MAX) shadow_pops = shadow_pops + 1'b1;
            end
        end else if (op == OP_SEARCH) begin
            foreach (shadow_list[i]) begin
                if (shadow_list[i] == key) r.found = 1'b1;
            end
        end
        r.occupancy     = 11'(shadow_list.size());
        r.removals_done = shadow_pops;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(list_op_result(cur_op, cur_key));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0
                        && !(pending_reqs[0].wait_idle && expected_results.size() != 0)
                        && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    cur_op  = nxt.op;
                    cur_key = nxt.key;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, nxt.key, nxt.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status        = t_status'(m_axis_tdata[1:0]);
                got.removed_key   = m_axis_tdata[21:2];
                got.found         = m_axis_tdata[22];
                got.occupancy     = m_axis_tdata[33:23];
                got.removals_done = m_axis_tdata[53:34];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected response: status %0d key %0d found %0d occ %0d pops %0d",
                                 got.status, got.removed_key, got.found, got.occupancy,
                                 got.removals_done);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.removed_key !== want.removed_key
                            || got.found !== want.found || got.occupancy !== want.occupancy
                            || got.removals_done !== want.removals_done) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch exp: status %0d key %0d found %0d occ %0d pops %0d",
                                     want.status, want.removed_key, want.found,
                                     want.occupancy, want.removals_done);
                            $display("         got: status %0d key %0d found %0d occ %0d pops %0d",
                                     got.status, got.removed_key, got.found,
                                     got.occupancy, got.removals_done);
                        end
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL sorted_list_insert_popmin_search");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(logic [1:0] op, logic [KEY_BITS-1:0] key, bit wait_idle = 1'b0);
        t_req r;
        r.op = op;
        r.key = key;
        r.wait_idle = wait_idle;
        pending_reqs.push_back(r);
        if (op == OP_INSERT && gen_occ < CAPACITY) begin
            gen_occ++;
            recent_keys[recent_n % 16] = key;
            recent_n++;
        end else if (op == OP_REMOVE && gen_occ > 0) begin
            gen_occ--;
        end
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return KEY_MAX;
        if (r < 40 && recent_n > 0) return recent_keys[$urandom_range((recent_n < 16 ? recent_n : 16) - 1)];
        return KEY_BITS'($urandom_range(KEY_MAX));
    endfunction

    // random mix that hovers around a target fill level
    task automatic random_reqs(int n, int target, int hold_at);
        int r;
        int ins_pct;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            ins_pct = (gen_occ < target) ? 50 : 25;
            if (r < ins_pct)
                push_req(OP_INSERT, pick_key(), i == hold_at);
            else if (r < 75)
                push_req(OP_REMOVE, KEY_BITS'($urandom_range(KEY_MAX)), i == hold_at);
            else if (r < 97)
                push_req(OP_SEARCH, pick_key(), i == hold_at);
            else
                push_req(OP_UNUSED, KEY_BITS'($urandom_range(KEY_MAX)), i == hold_at);
        end
    endtask

    // empty the list, fill it in ascending order, poke it while full, trim it
    task automatic fill_and_drain();
        logic [KEY_BITS-1:0] k;
        logic [KEY_BITS-1:0] lowest;
        while (gen_occ > 0) push_req(OP_REMOVE, KEY_BITS'($urandom_range(KEY_MAX)));
        k = KEY_BITS'($urandom_range(999));
        lowest = k;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == CAPACITY - 1) k = KEY_MAX;
            push_req(OP_INSERT, k);
            k = k + KEY_BITS'($urandom_range(999));
        end
        for (int i = 0; i < 3; i++) push_req(OP_INSERT, KEY_BITS'($urandom_range(KEY_MAX)));
        push_req(OP_INSERT, '0);
        push_req(OP_SEARCH, lowest);
        push_req(OP_SEARCH, KEY_MAX);
        push_req(OP_SEARCH, KEY_BITS'($urandom_range(KEY_MAX)));
        push_req(OP_REMOVE, '0);
        push_req(OP_INSERT, KEY_MAX);
        push_req(OP_INSERT, MID_KEY);
        for (int i = 0; i < 64; i++) push_req(OP_REMOVE, KEY_BITS'($urandom_range(KEY_MAX)));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_idling(int src_pct, int sink_pct);
        @(negedge i_clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty, unused opcode, duplicates, key extremes
        push_req(OP_REMOVE, KEY_MAX);
        push_req(OP_SEARCH, '0);
        push_req(OP_UNUSED, KEY_MAX);
        push_req(OP_INSERT, MID_KEY);
        push_req(OP_INSERT, '0);
        push_req(OP_INSERT, KEY_MAX);
        push_req(OP_INSERT, MID_KEY);
        push_req(OP_SEARCH, MID_KEY);
        push_req(OP_SEARCH, MID_KEY - 1'b1);
        push_req(OP_SEARCH, KEY_MAX);
        push_req(OP_SEARCH, '0);
        push_req(OP_UNUSED, '0);
        push_req(OP_REMOVE, KEY_MAX);
        push_req(OP_REMOVE, '0);
        push_req(OP_REMOVE, '0);
        push_req(OP_SEARCH, MID_KEY);
        push_req(OP_REMOVE, '0);
        push_req(OP_REMOVE, '0);
        push_req(OP_INSERT, 20'h55555);
        push_req(OP_INSERT, 20'hAAAAA);
        push_req(OP_SEARCH, 20'hAAAAA);
        push_req(OP_REMOVE, '0);
        push_req(OP_REMOVE, '0);
        wait_drained();

        fill_and_drain();
        random_reqs(100, 40, -1);
        wait_drained();

        set_idling(88, 0);
        random_reqs(100, 12, 50);
        wait_drained();

        set_idling(0, 88);
        random_reqs(100, 120, -1);
        wait_drained();

        set_idling(29, 29);
        random_reqs(100, 40, -1);
        wait_drained();

        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS sorted_list_insert_popmin_search");
        end else begin
            $display("FAIL sorted_list_insert_popmin_search");
        end
        $finish;
    end

endmodule
